FILE: rtl/assert_macros.svh
// Assertion macros for the RTL; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/ipsc_pkg.sv
// Types, codes and helpers of the idle power state controller.
`timescale 1ns / 1ps
package ipsc_pkg;

    localparam int unsigned CFG_W      = 12;
    localparam int unsigned CNT_W      = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_TOUCH = 2'd1,
        CMD_WAKE  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        PS_AWAKE = 2'd0,
        PS_DIM   = 2'd1,
        PS_LIGHT = 2'd2,
        PS_DEEP  = 2'd3
    } pstate_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIM_TIMEOUT   = 2'd0,
        REG_SLEEP_TIMEOUT = 2'd1,
        REG_DEEP_TIMEOUT  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       touch_pin_low;
    } in_beat_t;

    typedef struct packed {
        logic [1:0] power_state;
        logic       display_enable;
        logic       radio_save;
        logic       deep_sleep_enter;
        logic       state_changed;
    } out_beat_t;

    // Seconds to 100 ms ticks: s * 10 = s * 8 + s * 2, never above 40950.
    function automatic logic [CNT_W-1:0] secs_to_ticks(input logic [CFG_W-1:0] secs);
        logic [CNT_W-1:0] wide;
        wide = CNT_W'(secs);
        return (wide << 3) + (wide << 1);
    endfunction

endpackage

FILE: rtl/idle_power_state_controller_unit.sv
// Idle power state controller: one input beat is accepted per cycle, back to back, while the output side keeps up.
// Latency: the result beat is valid in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while the output side keeps up; state and idle count update with each accepted beat.
// Reset (aresetn low, synchronous): state awake, idle count zero, thresholds 30/60/300 s,
// output register empty. The configuration port is always ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module idle_power_state_controller_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  ipsc_pkg::in_beat_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output ipsc_pkg::out_beat_t              m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ipsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ipsc_pkg::CFG_W-1:0]       cfg_data
);
    import ipsc_pkg::*;

    // Thresholds are kept already converted to ticks, so the compare path
    // holds only the counter increment and a 16-bit compare.
    logic [CNT_W-1:0] dim_ticks_reg;
    logic [CNT_W-1:0] sleep_ticks_reg;
    logic [CNT_W-1:0] deep_ticks_reg;

    pstate_t          state_reg;
    pstate_t          state_next;
    logic [CNT_W-1:0] idle_reg;
    logic [CNT_W-1:0] idle_next;
    logic [CNT_W-1:0] idle_inc;

    logic             m_valid_reg;
    out_beat_t        m_data_reg;
    out_beat_t        m_data_next;

    logic             s_fire;
    logic             cfg_fire;

    // The output register frees up in the same cycle its beat is taken, so a
    // new beat enters every cycle as long as the downstream side keeps up.
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Saturating idle counter increment.
    assign idle_inc = (idle_reg == COUNT_MAX) ? idle_reg : idle_reg + CNT_W'(1);

    // Next state for the beat on the input port.
    always_comb begin
        state_next = state_reg;
        idle_next  = idle_reg;
        unique case (s_data.cmd)
            CMD_TICK: begin
                if (state_reg != PS_DEEP) begin
                    idle_next = idle_inc;
                end
                unique case (state_reg)
                    PS_AWAKE: begin
                        if (idle_inc >= dim_ticks_reg) begin
                            state_next = PS_DIM;
                        end
                    end
                    PS_DIM: begin
                        if (s_data.touch_pin_low) begin
                            state_next = PS_AWAKE;
                            idle_next  = '0;
                        end else if (idle_inc >= sleep_ticks_reg) begin
                            state_next = PS_LIGHT;
                        end
                    end
                    PS_LIGHT: begin
                        // A low pin or a count under the sleep threshold (left by
                        // a touch notification) wakes from light sleep.
                        if (s_data.touch_pin_low || idle_inc < sleep_ticks_reg) begin
                            state_next = PS_AWAKE;
                            idle_next  = '0;
                        end else if (idle_inc >= deep_ticks_reg) begin
                            state_next = PS_DEEP;
                        end
                    end
                    PS_DEEP: begin
                        state_next = PS_DEEP;
                    end
                    default: begin
                        state_next = state_reg;
                    end
                endcase
            end
            CMD_TOUCH: begin
                if (state_reg != PS_DEEP) begin
                    idle_next = '0;
                end
                if (state_reg == PS_DIM) begin
                    state_next = PS_AWAKE;
                end
            end
            CMD_WAKE: begin
                if (state_reg == PS_DIM || state_reg == PS_LIGHT) begin
                    state_next = PS_AWAKE;
                    idle_next  = '0;
                end
            end
            default: begin
                // The unused command code leaves everything as it is.
                state_next = state_reg;
            end
        endcase
    end

    // Result beat derived from the state after the item.
    always_comb begin
        m_data_next.power_state      = state_next;
        m_data_next.display_enable   = (state_next == PS_AWAKE);
        m_data_next.radio_save       = (state_next == PS_LIGHT);
        m_data_next.deep_sleep_enter = (state_next == PS_DEEP) && (state_reg != PS_DEEP);
        m_data_next.state_changed    = (state_next != state_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= PS_AWAKE;
            idle_reg        <= '0;
            m_valid_reg     <= 1'b0;
            dim_ticks_reg   <= secs_to_ticks(CFG_W'(30));
            sleep_ticks_reg <= secs_to_ticks(CFG_W'(60));
            deep_ticks_reg  <= secs_to_ticks(CFG_W'(300));
        end else begin
            if (s_fire) begin
                state_reg   <= state_next;
                idle_reg    <= idle_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_fire) begin
                unique case (cfg_index)
                    REG_DIM_TIMEOUT:   dim_ticks_reg   <= secs_to_ticks(cfg_data);
                    REG_SLEEP_TIMEOUT: sleep_ticks_reg <= secs_to_ticks(cfg_data);
                    REG_DEEP_TIMEOUT:  deep_ticks_reg  <= secs_to_ticks(cfg_data);
                    default: begin
                        // Writes beyond the register list are dropped.
                        dim_ticks_reg <= dim_ticks_reg;
                    end
                endcase
            end
        end
    end

    // Payload register takes a new beat whenever one is accepted.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= m_data_next;
        end
    end

    // Deep sleep is left only through reset, and the idle count is frozen there.
    `ASSERT_NEXT(a_deep_holds, aclk, aresetn, state_reg == PS_DEEP, state_reg == PS_DEEP)
    `ASSERT_NEXT(a_deep_count_frozen, aclk, aresetn, state_reg == PS_DEEP, $stable(idle_reg))
    // A held result beat must block the input side.
    `ASSERT_SAME(a_no_overrun, aclk, aresetn, m_valid_reg && !m_ready, !s_ready)
    // Entering deep sleep is always a state change into deep sleep.
    `ASSERT_SAME(a_deep_enter_ok, aclk, aresetn, m_valid_reg && m_data_reg.deep_sleep_enter, m_data_reg.state_changed && m_data_reg.power_state == PS_DEEP)
    // An accepted beat leaves a stored state equal to the one it reports.
    `ASSERT_NEXT(a_state_reported, aclk, aresetn, s_fire, m_data_reg.power_state == state_reg)

endmodule

FILE: tb/ipsc_power_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the idle power state controller: predicts each result beat and compares it.
module ipsc_power_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  ipsc_pkg::in_beat_t             s_data,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  ipsc_pkg::out_beat_t            m_data,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [ipsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ipsc_pkg::CFG_W-1:0]     cfg_data,
    output int                             fail_count,
    output int                             outstanding
);
    import ipsc_pkg::*;

    pstate_t          ps;
    logic [CNT_W-1:0] idle_cnt;
    logic [CFG_W-1:0] dim_s;
    logic [CFG_W-1:0] sleep_s;
    logic [CFG_W-1:0] deep_s;
    out_beat_t        expected_q[$];

    function automatic void return_awake();
        ps       = PS_AWAKE;
        idle_cnt = '0;
    endfunction

    // Applies one command to the predicted state and returns the result beat it causes.
    function automatic out_beat_t advance_power_state(input in_beat_t b);
        pstate_t     prior;
        out_beat_t   r;
        int unsigned dim_lim;
        int unsigned sleep_lim;
        int unsigned deep_lim;
        prior     = ps;
        dim_lim   = 10 * int'(dim_s);
        sleep_lim = 10 * int'(sleep_s);
        deep_lim  = 10 * int'(deep_s);
        case (b.cmd)
            CMD_TICK: begin
                if (ps != PS_DEEP) begin
                    if (idle_cnt != COUNT_MAX)
                        idle_cnt = idle_cnt + 1'b1;
                    case (ps)
                        PS_AWAKE: begin
                            if (idle_cnt >= dim_lim)
                                ps = PS_DIM;
                        end
                        PS_DIM: begin
                            if (b.touch_pin_low)
                                return_awake();
                            else if (idle_cnt >= sleep_lim)
                                ps = PS_LIGHT;
                        end
                        default: begin
                            if (b.touch_pin_low || idle_cnt < sleep_lim)
                                return_awake();
                            else if (idle_cnt >= deep_lim)
                                ps = PS_DEEP;
                        end
                    endcase
                end
            end
            CMD_TOUCH: begin
                if (ps != PS_DEEP) begin
                    idle_cnt = '0;
                    if (ps == PS_DIM)
                        ps = PS_AWAKE;
                end
            end
            CMD_WAKE: begin
                if (ps == PS_DIM || ps == PS_LIGHT)
                    return_awake();
            end
            default: ;
        endcase
        r.power_state      = ps;
        r.display_enable   = (ps == PS_AWAKE);
        r.radio_save       = (ps == PS_LIGHT);
        r.deep_sleep_enter = (ps == PS_DEEP) && (prior != PS_DEEP);
        r.state_changed    = (ps != prior);
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        out_beat_t want;
        if (!aresetn) begin
            ps          = PS_AWAKE;
            idle_cnt    = '0;
            dim_s       = 12'd30;
            sleep_s     = 12'd60;
            deep_s      = 12'd300;
            fail_count  = 0;
            expected_q.delete();
            outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DIM_TIMEOUT:   dim_s   = cfg_data;
                    REG_SLEEP_TIMEOUT: sleep_s = cfg_data;
                    REG_DEEP_TIMEOUT:  deep_s  = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_q.push_back(advance_power_state(s_data));
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result beat with nothing expected: %p", m_data);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("power_state", 32'(want.power_state),
                                32'(m_data.power_state));
                    check_field("display_enable", 32'(want.display_enable),
                                32'(m_data.display_enable));
                    check_field("radio_save", 32'(want.radio_save),
                                32'(m_data.radio_save));
                    check_field("deep_sleep_enter", 32'(want.deep_sleep_enter),
                                32'(m_data.deep_sleep_enter));
                    check_field("state_changed", 32'(want.state_changed),
                                32'(m_data.state_changed));
                end
            end
            outstanding <= expected_q.size();
        end
    end

endmodule

FILE: tb/tb_idle_power_state_controller_unit.sv
`timescale 1ns / 1ps
// Testbench top for the idle power state controller: stimulus, receiver, watchdog and verdict.
module tb_idle_power_state_controller_unit;
    import ipsc_pkg::*;

    // Command code 3 has no name in the package; the block must ignore it.
    localparam logic [1:0]           CMD_UNUSED     = 2'd3;
    // Register index 3 does not exist; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED     = 2'd3;
    localparam logic [CFG_W-1:0]     SECS_MAX       = '1;
    // The longest quiet stretch of a correct run is the receiver hold-off.
    localparam int                   WATCHDOG_LIMIT = 2000;
    localparam int                   HOLD_OFF_CYCLES = 300;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_beat_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_beat_t            m_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int fail_count;
    int outstanding;
    int quiet_cycles;

    // Idling controls, in percent: the sender leaves gaps, the receiver stalls.
    int send_idle_pct;
    int recv_stall_pct;
    // Set by the stimulus to ask the receiver for one long hold-off.
    bit hold_request;

    idle_power_state_controller_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ipsc_power_checker u_power_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // 4 ns clock period.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Receiver: stalls at random, or holds off for a long stretch when asked so
    // that the block fills up and has to push back on its input.
    initial begin
        int hold_left;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: any cycle with a handshake on some channel restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic in_beat_t beat_of(input logic [1:0] cmd, input logic pin_low);
        in_beat_t b;
        b.cmd           = cmd;
        b.touch_pin_low = pin_low;
        return b;
    endfunction

    // Random activity: mostly untouched ticks so the idle count climbs through the
    // thresholds, with touches, wake requests, pin wakes and the unused code mixed in.
    // The pin bit is random on non-tick commands, where it must have no effect.
    function automatic in_beat_t activity_beat();
        int unsigned roll;
        in_beat_t    b;
        roll            = $urandom_range(99);
        b.touch_pin_low = 1'($urandom_range(1));
        if (roll < 80) begin
            b.cmd           = CMD_TICK;
            b.touch_pin_low = ($urandom_range(99) < 6);
        end else if (roll < 88) begin
            b.cmd = CMD_TOUCH;
        end else if (roll < 96) begin
            b.cmd = CMD_WAKE;
        end else begin
            b.cmd = CMD_UNUSED;
        end
        return b;
    endfunction

    // Waits until every expected result has come back, then waits on briefly.
    // It always waits for a clock edge first, so the outstanding count it reads already
    // includes a beat accepted at the edge where the caller stood.
    task automatic wait_drained();
        do
            @(posedge aclk);
        while (outstanding != 0);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_thresholds(input logic [CFG_W-1:0] dim_s, input logic [CFG_W-1:0] sleep_s,
                                  input logic [CFG_W-1:0] deep_s);
        write_reg(REG_DIM_TIMEOUT, dim_s);
        write_reg(REG_SLEEP_TIMEOUT, sleep_s);
        write_reg(REG_DEEP_TIMEOUT, deep_s);
    endtask

    // Offers one beat and returns once it is accepted. A gap, when one is drawn, lowers
    // valid right at the accepting edge, and the task idles before returning.
    task automatic send_beat(input in_beat_t b);
        s_valid <= 1'b1;
        s_data  <= b;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do
                @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic send_beats(input in_beat_t beats[$]);
        foreach (beats[i])
            send_beat(beats[i]);
        s_valid <= 1'b0;
    endtask

    task automatic send_random(input int count);
        in_beat_t beats[$];
        repeat (count)
            beats.push_back(activity_beat());
        send_beats(beats);
    endtask

    // One random phase: new thresholds written while idle, then a burst of activity
    // under the given idling.
    task automatic run_phase(input logic [CFG_W-1:0] dim_s, input logic [CFG_W-1:0] sleep_s,
                             input logic [CFG_W-1:0] deep_s, input int send_pct,
                             input int stall_pct, input int count);
        set_thresholds(dim_s, sleep_s, deep_s);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        send_random(count);
    endtask

    initial begin
        in_beat_t script[$];
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. With zero dim and sleep thresholds every tick in awake or dim moves the
        // state on, so each transition can be reached in a beat or two. The deep
        // threshold stays at its maximum so deep sleep is not entered yet.
        set_thresholds('0, '0, SECS_MAX);
        script = '{
            beat_of(CMD_UNUSED, 1'b1),   // unused code in awake: nothing moves
            beat_of(CMD_WAKE,   1'b1),   // wake request while already awake
            beat_of(CMD_TOUCH,  1'b1),   // touch in awake only clears the count
            beat_of(CMD_TICK,   1'b0),   // zero dim threshold: awake turns dim
            beat_of(CMD_UNUSED, 1'b0),   // unused code in dim
            beat_of(CMD_TOUCH,  1'b0),   // touch wakes from dim
            beat_of(CMD_TICK,   1'b0),
            beat_of(CMD_WAKE,   1'b0),   // wake request from dim
            beat_of(CMD_TICK,   1'b0),
            beat_of(CMD_TICK,   1'b1),   // low pin on a tick wakes from dim
            beat_of(CMD_TICK,   1'b0),
            beat_of(CMD_TICK,   1'b0),   // dim turns light sleep
            beat_of(CMD_TOUCH,  1'b1),   // touch in light sleep keeps the state
            beat_of(CMD_TICK,   1'b0),   // zero sleep threshold: the low count never wakes
            beat_of(CMD_UNUSED, 1'b1),   // unused code in light sleep
            beat_of(CMD_WAKE,   1'b1),   // wake request from light sleep
            beat_of(CMD_TICK,   1'b0),
            beat_of(CMD_TICK,   1'b0),
            beat_of(CMD_TICK,   1'b1)    // low pin wakes from light sleep
        };
        send_beats(script);

        // Random phases. Small thresholds in most phases keep the state cycling through awake, dim
        // and light sleep; the deep threshold stays out of reach until the end,
        // since deep sleep only leaves on reset.
        run_phase(12'd1, 12'd2, SECS_MAX, 0, 0, 160);
        run_phase(12'd0, 12'd3, SECS_MAX, 88, 0, 160);
        run_phase(SECS_MAX, SECS_MAX, SECS_MAX, 0, 88, 100);
        run_phase(12'd2, 12'd0, SECS_MAX, 25, 25, 160);

        // Back pressure: the receiver holds off while the sender keeps offering.
        set_thresholds(12'd1, 12'd1, SECS_MAX);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b1;
        send_random(160);

        // A write to the missing register must leave the thresholds alone.
        write_reg(REG_UNUSED, CFG_W'($urandom_range(SECS_MAX)));
        run_phase(12'd3, 12'd5, SECS_MAX, 88, 88, 160);

        // Deep sleep last: with all thresholds at zero at most three ticks walk the
        // state on to deep sleep, after which every command has to be ignored.
        set_thresholds('0, '0, '0);
        send_idle_pct  = 25;
        recv_stall_pct = 25;
        script = '{
            beat_of(CMD_TICK,   1'b0),
            beat_of(CMD_TICK,   1'b0),
            beat_of(CMD_TICK,   1'b0),   // deep sleep is reached by here
            beat_of(CMD_TOUCH,  1'b0),
            beat_of(CMD_WAKE,   1'b1),
            beat_of(CMD_TICK,   1'b1),
            beat_of(CMD_UNUSED, 1'b0)
        };
        send_beats(script);
        send_random(20);

        wait_drained();
        repeat (4) @(posedge aclk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
